// ===== hdl/pnh_pkg.sv =====
// Package for the pileup noise histogram core: widths, codes and payload types.
// No dependencies.
package pnh_pkg;

    localparam int MAX_BINS   = 256;
    localparam int BIN_BITS   = $clog2(MAX_BINS);
    localparam int COUNT_BITS = 16;
    localparam int TOTAL_BITS = 48;
    localparam int HIST_BITS  = 32;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = {TOTAL_BITS{1'b1}};
    localparam logic [HIST_BITS-1:0]  HIST_MAX  = {HIST_BITS{1'b1}};

    localparam logic [1:0] FUNC_CHAR = 2'd0;
    localparam logic [1:0] FUNC_EOP  = 2'd1;
    localparam logic [1:0] FUNC_BIN  = 2'd2;
    localparam logic [1:0] FUNC_TOT  = 2'd3;

    localparam logic [1:0] REG_MIN_DEPTH    = 2'd0;
    localparam logic [1:0] REG_PER_POSITION = 2'd1;
    localparam logic [1:0] REG_DIFF_TYPE    = 2'd2;

    localparam logic [2:0] DT_ALL = 3'd0;
    localparam logic [2:0] DT_MIS = 3'd1;
    localparam logic [2:0] DT_DEL = 3'd2;
    localparam logic [2:0] DT_INS = 3'd3;
    localparam logic [2:0] DT_MAX = 3'd4;

    localparam logic [1:0] PM_NORMAL = 2'd0;
    localparam logic [1:0] PM_SKIP1  = 2'd1;
    localparam logic [1:0] PM_DIGITS = 2'd2;
    localparam logic [1:0] PM_SKIPN  = 2'd3;

    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  base_char;
        logic [15:0] depth;
        logic [7:0]  ref_base;
        logic [7:0]  read_index;
    } in_item_t;

    typedef struct packed {
        logic [15:0] nr_diff;
        logic [15:0] nr_mismatch;
        logic [15:0] nr_del;
        logic [15:0] nr_ins;
        logic [15:0] count_a;
        logic [15:0] count_c;
        logic [15:0] count_g;
        logic [15:0] count_t;
        logic [15:0] max_mismatch;
        logic [7:0]  bin;
        logic        accepted;
        logic [47:0] read_value;
    } out_item_t;

    typedef struct packed {
        logic [1:0] index;
        logic [7:0] data;
    } cfg_word_t;

    // Request to the bin divider and its answer.
    typedef struct packed {
        logic        start;
        logic [23:0] num;
        logic [15:0] den;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [15:0] quot;
        logic        rem_nz;
    } div_rsp_t;

endpackage

// ===== hdl/pnh_if.sv =====
// Valid/ready channel interfaces for items, results and configuration words.
// Depends on pnh_pkg.
interface pnh_in_if;
    logic valid;
    logic ready;
    pnh_pkg::in_item_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface pnh_out_if;
    logic valid;
    logic ready;
    pnh_pkg::out_item_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface pnh_cfg_if;
    logic valid;
    logic ready;
    pnh_pkg::cfg_word_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== hdl/pnh_div.sv =====
// Restoring divider, one quotient bit per cycle, for the bin calculation.
// Depends on pnh_pkg.
module pnh_div
(
    input  logic              clk,
    input  logic              rst_n,
    input  pnh_pkg::div_req_t req,
    output pnh_pkg::div_rsp_t rsp
);
    logic [15:0] quot_reg, quot_next;
    logic [16:0] rem_reg, rem_next;
    logic [15:0] den_reg;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [16:0] trial;

    always_comb
    begin
        trial     = {rem_reg[15:0], quot_reg[15]};
        quot_next = quot_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            // The quotient always fits 16 bits, so the top byte of the
            // numerator is below the divisor and can seed the remainder.
            quot_next = req.num[15:0];
            rem_next  = {9'd0, req.num[23:16]};
            cnt_next  = 5'd16;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next  = trial - {1'b0, den_reg};
                quot_next = {quot_reg[14:0], 1'b1};
            end
            else
            begin
                rem_next  = trial;
                quot_next = {quot_reg[14:0], 1'b0};
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        if (req.start)
        begin
            den_reg <= req.den;
        end
    end

    assign rsp.done   = done_reg;
    assign rsp.quot   = quot_reg;
    assign rsp.rem_nz = (rem_reg != '0);

    always_ff @(posedge clk)
    begin
        if (rst_n && busy_reg && req.start)
        begin
            $error("divider restarted while busy");
        end
    end
endmodule

// ===== hdl/pileup_noise_histogram_core.sv =====
// Pileup noise histogram core: top level with parser, counters, histogram RAM.
// Depends on pnh_pkg, pnh_if and pnh_div.
//
// Base characters (func 0) are taken one per cycle while the sequencer is
// idle and give no result word. A total read or an unbinned end-of-position
// word goes straight to the emit step; a histogram read passes through the
// RAM read step first; a binned position passes through the histogram read
// and write steps, after the 16-step divider when it has differences.
// After reset the 256-entry histogram RAM is cleared one entry a cycle,
// during which no item word is taken; configuration words are taken at
// all times. A result word may wait at the output register while the next
// item enters; a second result word then waits in the emit step.
module pileup_noise_histogram_core
(
    input  logic         clk,
    input  logic         rst_n,
    pnh_in_if.sink       in_ch,
    pnh_out_if.source    out_ch,
    pnh_cfg_if.sink      cfg
);
    typedef enum logic [6:0] {
        ST_CLEAR = 7'b0000001,
        ST_IDLE  = 7'b0000010,
        ST_DIV   = 7'b0000100,
        ST_HRD   = 7'b0001000,
        ST_HWR   = 7'b0010000,
        ST_EMIT  = 7'b0100000,
        ST_RDH   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [7:0] min_depth_reg;
    logic       per_position_reg;
    logic [2:0] diff_type_reg;

    logic [1:0]  pm_reg, pm_next;
    logic [15:0] skip_reg, skip_next;
    logic [15:0] pc_reg [9];
    logic [15:0] pc_next [9];
    logic [47:0] tot_reg [4];
    logic [47:0] tot_next [4];

    logic [31:0] hist_mem [pnh_pkg::MAX_BINS];
    logic [31:0] hist_rd_reg;
    logic [pnh_pkg::BIN_BITS-1:0] hist_addr;
    logic        hist_we;
    logic [31:0] hist_wd;
    logic [pnh_pkg::BIN_BITS-1:0] clr_reg;

    pnh_pkg::out_item_t res_reg, res_next;
    pnh_pkg::out_item_t out_reg;
    logic        out_valid_reg;
    logic        emit_go;
    logic [pnh_pkg::BIN_BITS-1:0] bin_reg, bin_next;

    pnh_pkg::div_req_t div_req;
    pnh_pkg::div_rsp_t div_rsp;

    pnh_pkg::in_item_t it;
    logic        take;
    logic [7:0]  c, u, refb;
    logic [15:0] maxm, diffs;
    logic [15:0] cnt [4];
    logic [19:0] acc10;
    logic [23:0] prod;
    logic        accept_pos;
    logic [16:0] qbin;

    pnh_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));

    assign it = in_ch.payload;
    assign in_ch.ready = (state_reg == ST_IDLE);
    assign take = in_ch.valid && in_ch.ready;
    assign cfg.ready = 1'b1;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.payload = out_reg;
    assign emit_go = (state_reg == ST_EMIT) && (!out_valid_reg || out_ch.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_depth_reg    <= 8'd20;
            per_position_reg <= 1'b0;
            diff_type_reg    <= pnh_pkg::DT_ALL;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.payload.index)
                pnh_pkg::REG_MIN_DEPTH:    min_depth_reg <= cfg.payload.data;
                pnh_pkg::REG_PER_POSITION: per_position_reg <= cfg.payload.data[0];
                pnh_pkg::REG_DIFF_TYPE:    diff_type_reg <= cfg.payload.data[2:0];
                default: ;
            endcase
        end
    end

    function automatic logic [15:0] sat_inc(input logic [15:0] v);
        sat_inc = (v == pnh_pkg::COUNT_MAX) ? v : v + 16'd1;
    endfunction

    function automatic logic [47:0] tot_inc(input logic [47:0] v);
        tot_inc = (v == pnh_pkg::TOTAL_MAX) ? v : v + 48'd1;
    endfunction

    // Per-position counts and the report fields derived from them.
    always_comb
    begin
        maxm = '0;
        for (int k = 0; k < 4; k++)
        begin
            cnt[k] = pc_reg[4 + k];
            if (pc_reg[4 + k] > maxm)
            begin
                maxm = pc_reg[4 + k];
            end
        end
        refb = it.ref_base & 8'hDF;
        if (refb == 8'h41) cnt[0] = pc_reg[8];
        else if (refb == 8'h43) cnt[1] = pc_reg[8];
        else if (refb == 8'h47) cnt[2] = pc_reg[8];
        else if (refb == 8'h54 || refb == 8'h55) cnt[3] = pc_reg[8];
        case (diff_type_reg)
            pnh_pkg::DT_MIS: diffs = pc_reg[1];
            pnh_pkg::DT_DEL: diffs = pc_reg[2];
            pnh_pkg::DT_INS: diffs = pc_reg[3];
            pnh_pkg::DT_MAX: diffs = maxm;
            default:         diffs = pc_reg[0];
        endcase
        if (diffs > it.depth)
        begin
            diffs = it.depth;
        end
        prod = {8'd0, diffs} * {16'd0, min_depth_reg};
        accept_pos = (it.depth >= {8'd0, min_depth_reg});
    end

    // Character parser.
    always_comb
    begin
        c = it.base_char;
        u = c & 8'hDF;
        pm_next = pm_reg;
        skip_next = skip_reg;
        acc10 = {skip_reg, 3'd0} + {3'd0, skip_reg, 1'b0} + {12'd0, c - 8'd48};
        for (int k = 0; k < 9; k++)
        begin
            pc_next[k] = pc_reg[k];
        end
        for (int k = 0; k < 4; k++)
        begin
            tot_next[k] = tot_reg[k];
        end
        if (take && it.func == pnh_pkg::FUNC_EOP)
        begin
            pm_next = pnh_pkg::PM_NORMAL;
            skip_next = '0;
            for (int k = 0; k < 9; k++)
            begin
                pc_next[k] = '0;
            end
        end
        else if (take && it.func == pnh_pkg::FUNC_CHAR)
        begin
            logic normal;
            normal = 1'b0;
            case (pm_reg)
                pnh_pkg::PM_SKIP1: pm_next = pnh_pkg::PM_NORMAL;
                pnh_pkg::PM_DIGITS:
                begin
                    if (c >= 8'h30 && c <= 8'h39)
                    begin
                        skip_next = (acc10 > 20'd65535) ? 16'hFFFF : acc10[15:0];
                    end
                    else if (skip_reg != '0)
                    begin
                        skip_next = skip_reg - 16'd1;
                        pm_next = (skip_reg == 16'd1) ? pnh_pkg::PM_NORMAL
                                                      : pnh_pkg::PM_SKIPN;
                    end
                    else
                    begin
                        pm_next = pnh_pkg::PM_NORMAL;
                        normal = 1'b1;
                    end
                end
                pnh_pkg::PM_SKIPN:
                begin
                    if (skip_reg != '0)
                    begin
                        skip_next = skip_reg - 16'd1;
                    end
                    if (skip_reg <= 16'd1)
                    begin
                        pm_next = pnh_pkg::PM_NORMAL;
                    end
                end
                default: normal = 1'b1;
            endcase
            if (normal)
            begin
                if (c == 8'h2B)
                begin
                    pc_next[0] = sat_inc(pc_reg[0]);
                    pc_next[3] = sat_inc(pc_reg[3]);
                    tot_next[3] = tot_inc(tot_reg[3]);
                    pm_next = pnh_pkg::PM_DIGITS;
                    skip_next = '0;
                end
                else if (c == 8'h2D)
                begin
                    pm_next = pnh_pkg::PM_DIGITS;
                    skip_next = '0;
                end
                else if (c == 8'h5E)
                begin
                    pm_next = pnh_pkg::PM_SKIP1;
                end
                else if (u >= 8'h41 && u <= 8'h5A && c[6])
                begin
                    pc_next[0] = sat_inc(pc_reg[0]);
                    pc_next[1] = sat_inc(pc_reg[1]);
                    tot_next[0] = tot_inc(tot_reg[0]);
                    tot_next[1] = tot_inc(tot_reg[1]);
                    if (u == 8'h41) pc_next[4] = sat_inc(pc_reg[4]);
                    else if (u == 8'h43) pc_next[5] = sat_inc(pc_reg[5]);
                    else if (u == 8'h47) pc_next[6] = sat_inc(pc_reg[6]);
                    else if (u == 8'h54 || u == 8'h55) pc_next[7] = sat_inc(pc_reg[7]);
                end
                else if (c == 8'h2A || c == 8'h23)
                begin
                    pc_next[0] = sat_inc(pc_reg[0]);
                    pc_next[2] = sat_inc(pc_reg[2]);
                    tot_next[2] = tot_inc(tot_reg[2]);
                end
                else if (c == 8'h2E || c == 8'h2C)
                begin
                    pc_next[8] = sat_inc(pc_reg[8]);
                    tot_next[0] = tot_inc(tot_reg[0]);
                end
            end
        end
    end

    // Sequencer for the histogram clear, end-of-position and read words.
    always_comb
    begin
        state_next = state_reg;
        res_next = res_reg;
        bin_next = bin_reg;
        div_req.start = 1'b0;
        div_req.num = prod;
        div_req.den = it.depth;
        hist_we = 1'b0;
        hist_wd = (hist_rd_reg == pnh_pkg::HIST_MAX) ? hist_rd_reg : hist_rd_reg + 32'd1;
        hist_addr = bin_reg;
        qbin = {1'b0, div_rsp.quot} + {16'd0, div_rsp.rem_nz};
        unique case (state_reg)
            ST_CLEAR:
            begin
                hist_we = 1'b1;
                hist_wd = '0;
                hist_addr = clr_reg;
                if (clr_reg == pnh_pkg::BIN_BITS'(pnh_pkg::MAX_BINS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                hist_addr = it.read_index[pnh_pkg::BIN_BITS-1:0];
                if (take && it.func != pnh_pkg::FUNC_CHAR)
                begin
                    res_next = '0;
                    if (it.func == pnh_pkg::FUNC_EOP)
                    begin
                        res_next.nr_diff = pc_reg[0];
                        res_next.nr_mismatch = pc_reg[1];
                        res_next.nr_del = pc_reg[2];
                        res_next.nr_ins = pc_reg[3];
                        res_next.count_a = cnt[0];
                        res_next.count_c = cnt[1];
                        res_next.count_g = cnt[2];
                        res_next.count_t = cnt[3];
                        res_next.max_mismatch = maxm;
                        res_next.accepted = accept_pos;
                        if (accept_pos && !per_position_reg)
                        begin
                            bin_next = '0;
                            if (diffs != '0)
                            begin
                                div_req.start = 1'b1;
                                state_next = ST_DIV;
                            end
                            else
                            begin
                                state_next = ST_HRD;
                            end
                        end
                        else
                        begin
                            state_next = ST_EMIT;
                        end
                    end
                    else if (it.func == pnh_pkg::FUNC_BIN)
                    begin
                        state_next = (it.read_index < 8'(pnh_pkg::MAX_BINS) ||
                                      pnh_pkg::MAX_BINS > 255) ? ST_RDH : ST_EMIT;
                    end
                    else
                    begin
                        if (it.read_index < 8'd4)
                        begin
                            res_next.read_value = tot_reg[it.read_index[1:0]];
                        end
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    bin_next = (qbin > 17'(pnh_pkg::MAX_BINS - 1)) ?
                               pnh_pkg::BIN_BITS'(pnh_pkg::MAX_BINS - 1) :
                               qbin[pnh_pkg::BIN_BITS-1:0];
                    state_next = ST_HRD;
                end
            end
            ST_HRD:
            begin
                state_next = ST_HWR;
            end
            ST_HWR:
            begin
                hist_we = 1'b1;
                res_next.bin = 8'(bin_reg);
                state_next = ST_EMIT;
            end
            ST_RDH:
            begin
                res_next.read_value = {16'd0, hist_rd_reg};
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                // Waits here while the output register still holds a word.
                if (emit_go)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (hist_we)
        begin
            hist_mem[hist_addr] <= hist_wd;
        end
        hist_rd_reg <= hist_mem[hist_addr];
        res_reg <= res_next;
        bin_reg <= bin_next;
        if (emit_go)
        begin
            out_reg <= res_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg <= '0;
            out_valid_reg <= 1'b0;
            pm_reg <= pnh_pkg::PM_NORMAL;
            skip_reg <= '0;
            for (int k = 0; k < 9; k++)
            begin
                pc_reg[k] <= '0;
            end
            for (int k = 0; k < 4; k++)
            begin
                tot_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (emit_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            pm_reg <= pm_next;
            skip_reg <= skip_next;
            for (int k = 0; k < 9; k++)
            begin
                pc_reg[k] <= pc_next[k];
            end
            for (int k = 0; k < 4; k++)
            begin
                tot_reg[k] <= tot_next[k];
            end
        end
    end

    // A waiting result word holds still until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ch.ready) |=> (out_valid_reg && $stable(out_reg)))
        else $error("result word changed while waiting");

    // The histogram is written back in the cycle after its read.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_HWR) |-> $past(state_reg == ST_HRD))
        else $error("histogram write without a preceding read");

    // A divider answer only arrives while the sequencer waits for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == ST_DIV))
        else $error("divider answer outside the divide step");

    // The result word is presented in the cycle after the emit step.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |=> out_valid_reg)
        else $error("result word not presented after emit");
endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for pileup_noise_histogram_core: pileup parsing, position
// reports, histogram binning and running totals, checked against an in-bench predictor.
// Depends on pnh_pkg, pnh_if and the core RTL.
`timescale 1ns / 1ps

module testbench;

    localparam int STALL_LIMIT = 5000;
    localparam int SETTLE      = 40;
    localparam int RANDOM_ITEMS = 560;

    logic clk;
    logic rst_n;

    pnh_in_if  in_ch ();
    pnh_out_if out_ch ();
    pnh_cfg_if cfg ();

    pileup_noise_histogram_core dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source),
        .cfg    (cfg.sink)
    );

    // Predictor state.
    logic [7:0]  min_depth_q;
    logic        per_position_q;
    logic [2:0]  diff_type_q;
    logic [1:0]  parse_mode;
    logic [15:0] skip_left;
    logic [15:0] pos_diff, pos_mis, pos_del, pos_ins, pos_match;
    logic [15:0] pos_base [4];
    logic [31:0] hist_bins [pnh_pkg::MAX_BINS];
    logic [47:0] run_totals [4];

    pnh_pkg::out_item_t expected_words [$];

    int send_idle;
    int recv_idle;
    int hold_left;
    int errors;
    int items_sent;
    int words_checked;
    int binned_positions;
    int stall_cycles;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic logic [15:0] sat16(logic [15:0] v);
        return (v == pnh_pkg::COUNT_MAX) ? v : v + 16'd1;
    endfunction

    function automatic logic [47:0] sat48(logic [47:0] v);
        return (v == pnh_pkg::TOTAL_MAX) ? v : v + 48'd1;
    endfunction

    function automatic void clear_position();
        pos_diff = '0;
        pos_mis = '0;
        pos_del = '0;
        pos_ins = '0;
        pos_match = '0;
        for (int k = 0; k < 4; k++)
            pos_base[k] = '0;
        parse_mode = pnh_pkg::PM_NORMAL;
        skip_left = '0;
    endfunction

    function automatic void count_char(logic [7:0] c);
        logic [7:0] u;
        u = c & 8'hDF;
        if (c == "+")
        begin
            pos_diff = sat16(pos_diff);
            pos_ins = sat16(pos_ins);
            run_totals[3] = sat48(run_totals[3]);
            parse_mode = pnh_pkg::PM_DIGITS;
            skip_left = '0;
        end
        else if (c == "-")
        begin
            parse_mode = pnh_pkg::PM_DIGITS;
            skip_left = '0;
        end
        else if (c == "^")
            parse_mode = pnh_pkg::PM_SKIP1;
        else if ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z"))
        begin
            pos_diff = sat16(pos_diff);
            pos_mis = sat16(pos_mis);
            run_totals[0] = sat48(run_totals[0]);
            run_totals[1] = sat48(run_totals[1]);
            if (u == "A")
                pos_base[0] = sat16(pos_base[0]);
            else if (u == "C")
                pos_base[1] = sat16(pos_base[1]);
            else if (u == "G")
                pos_base[2] = sat16(pos_base[2]);
            else if (u == "T" || u == "U")
                pos_base[3] = sat16(pos_base[3]);
        end
        else if (c == "*" || c == "#")
        begin
            pos_diff = sat16(pos_diff);
            pos_del = sat16(pos_del);
            run_totals[2] = sat48(run_totals[2]);
        end
        else if (c == "." || c == ",")
        begin
            pos_match = sat16(pos_match);
            run_totals[0] = sat48(run_totals[0]);
        end
    endfunction

    function automatic void parse_pileup_char(logic [7:0] c);
        logic [31:0] len;
        case (parse_mode)
            pnh_pkg::PM_SKIP1:
                parse_mode = pnh_pkg::PM_NORMAL;
            pnh_pkg::PM_DIGITS:
            begin
                if (c >= "0" && c <= "9")
                begin
                    len = skip_left * 32'd10 + 32'(c - "0");
                    skip_left = (len > 32'd65535) ? 16'hFFFF : len[15:0];
                end
                else if (skip_left != 0)
                begin
                    skip_left = skip_left - 16'd1;
                    parse_mode = (skip_left != 0) ? pnh_pkg::PM_SKIPN : pnh_pkg::PM_NORMAL;
                end
                else
                begin
                    parse_mode = pnh_pkg::PM_NORMAL;
                    count_char(c);
                end
            end
            pnh_pkg::PM_SKIPN:
            begin
                if (skip_left != 0)
                    skip_left = skip_left - 16'd1;
                if (skip_left == 0)
                    parse_mode = pnh_pkg::PM_NORMAL;
            end
            default:
                count_char(c);
        endcase
    endfunction

    // Works out the result word an accepted item gives, if any, and updates state.
    function automatic bit predict_pileup(pnh_pkg::in_item_t it,
                                          output pnh_pkg::out_item_t res);
        logic [15:0] cnt [4];
        logic [15:0] maxm;
        logic [15:0] diffs;
        logic [63:0] bin_full;
        logic [7:0]  refb;
        logic        acc;
        res = '0;
        if (it.func == pnh_pkg::FUNC_CHAR)
        begin
            parse_pileup_char(it.base_char);
            return 1'b0;
        end
        if (it.func == pnh_pkg::FUNC_BIN)
        begin
            res.read_value = {16'd0, hist_bins[it.read_index]};
            return 1'b1;
        end
        if (it.func == pnh_pkg::FUNC_TOT)
        begin
            if (it.read_index < 4)
                res.read_value = run_totals[it.read_index[1:0]];
            return 1'b1;
        end
        maxm = '0;
        for (int k = 0; k < 4; k++)
        begin
            cnt[k] = pos_base[k];
            if (cnt[k] > maxm)
                maxm = cnt[k];
        end
        acc = it.depth >= {8'd0, min_depth_q};
        if (acc && !per_position_q)
        begin
            case (diff_type_q)
                pnh_pkg::DT_MIS: diffs = pos_mis;
                pnh_pkg::DT_DEL: diffs = pos_del;
                pnh_pkg::DT_INS: diffs = pos_ins;
                pnh_pkg::DT_MAX: diffs = maxm;
                default: diffs = pos_diff;
            endcase
            if (diffs > it.depth)
                diffs = it.depth;
            bin_full = '0;
            if (diffs != 0)
                bin_full = (64'(min_depth_q) * 64'(diffs) + 64'(it.depth) - 64'd1)
                           / 64'(it.depth);
            if (bin_full > 64'(pnh_pkg::MAX_BINS - 1))
                bin_full = 64'(pnh_pkg::MAX_BINS - 1);
            res.bin = bin_full[7:0];
            if (hist_bins[res.bin] != pnh_pkg::HIST_MAX)
                hist_bins[res.bin] = hist_bins[res.bin] + 32'd1;
            binned_positions++;
        end
        refb = it.ref_base & 8'hDF;
        if (refb == "A")
            cnt[0] = pos_match;
        else if (refb == "C")
            cnt[1] = pos_match;
        else if (refb == "G")
            cnt[2] = pos_match;
        else if (refb == "T" || refb == "U")
            cnt[3] = pos_match;
        res.nr_diff = pos_diff;
        res.nr_mismatch = pos_mis;
        res.nr_del = pos_del;
        res.nr_ins = pos_ins;
        res.count_a = cnt[0];
        res.count_c = cnt[1];
        res.count_g = cnt[2];
        res.count_t = cnt[3];
        res.max_mismatch = maxm;
        res.accepted = acc;
        clear_position();
        return 1'b1;
    endfunction

    task automatic report_mismatch(string what, logic [47:0] got, logic [47:0] want);
        $display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    task automatic compare_field(string what, logic [47:0] got, logic [47:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    // Result checker.
    always @(posedge clk)
    begin
        pnh_pkg::out_item_t got;
        pnh_pkg::out_item_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got = out_ch.payload;
            words_checked++;
            if (expected_words.size() == 0)
                report_mismatch("unexpected result word", got.read_value, '0);
            else
            begin
                want = expected_words.pop_front();
                compare_field("nr_diff", got.nr_diff, want.nr_diff);
                compare_field("nr_mismatch", got.nr_mismatch, want.nr_mismatch);
                compare_field("nr_del", got.nr_del, want.nr_del);
                compare_field("nr_ins", got.nr_ins, want.nr_ins);
                compare_field("count_a", got.count_a, want.count_a);
                compare_field("count_c", got.count_c, want.count_c);
                compare_field("count_g", got.count_g, want.count_g);
                compare_field("count_t", got.count_t, want.count_t);
                compare_field("max_mismatch", got.max_mismatch, want.max_mismatch);
                compare_field("bin", got.bin, want.bin);
                compare_field("accepted", got.accepted, want.accepted);
                compare_field("read_value", got.read_value, want.read_value);
            end
        end
    end

    // Receiver: random stalls plus an optional long hold-off.
    always @(negedge clk)
        out_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle);

    always @(posedge clk)
        if (hold_left > 0)
            hold_left <= hold_left - 1;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                || (cfg.valid && cfg.ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("Timeout: no word moved for %0d cycles", STALL_LIMIT);
                $display("Verification failed");
                $finish;
            end
        end
    end

    function automatic pnh_pkg::in_item_t noisy_item();
        pnh_pkg::in_item_t it;
        it = pnh_pkg::in_item_t'({$urandom, $urandom});
        return it;
    endfunction

    // Leaves valid high after acceptance so that back-to-back words need no gap.
    task automatic send_word(pnh_pkg::in_item_t it);
        pnh_pkg::out_item_t res;
        @(negedge clk);
        if ($urandom_range(99) < send_idle)
        begin
            in_ch.valid <= 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(99) < send_idle);
        end
        in_ch.valid <= 1'b1;
        in_ch.payload <= it;
        do
            @(posedge clk);
        while (!in_ch.ready);
        items_sent++;
        if (predict_pileup(it, res))
            expected_words.push_back(res);
    endtask

    task automatic send_char(logic [7:0] c);
        pnh_pkg::in_item_t it;
        it = noisy_item();
        it.func = pnh_pkg::FUNC_CHAR;
        it.base_char = c;
        send_word(it);
    endtask

    task automatic send_text(string s);
        for (int k = 0; k < s.len(); k++)
            send_char(s[k]);
    endtask

    task automatic send_eop(logic [15:0] depth, logic [7:0] refb);
        pnh_pkg::in_item_t it;
        it = noisy_item();
        it.func = pnh_pkg::FUNC_EOP;
        it.depth = depth;
        it.ref_base = refb;
        send_word(it);
    endtask

    task automatic send_read(logic [1:0] func, logic [7:0] idx);
        pnh_pkg::in_item_t it;
        it = noisy_item();
        it.func = func;
        it.read_index = idx;
        send_word(it);
    endtask

    task automatic drain();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [7:0] data);
        drain();
        @(negedge clk);
        cfg.valid <= 1'b1;
        cfg.payload <= '{index: idx, data: data};
        do
            @(posedge clk);
        while (!cfg.ready);
        case (idx)
            pnh_pkg::REG_MIN_DEPTH: min_depth_q = data;
            pnh_pkg::REG_PER_POSITION: per_position_q = data[0];
            pnh_pkg::REG_DIFF_TYPE: diff_type_q = data[2:0];
            default: ;
        endcase
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    task automatic set_config(logic [7:0] md, logic pp, logic [2:0] dt);
        write_reg(pnh_pkg::REG_MIN_DEPTH, md);
        write_reg(pnh_pkg::REG_PER_POSITION, {7'd0, pp});
        write_reg(pnh_pkg::REG_DIFF_TYPE, {5'd0, dt});
    endtask

    // One pileup position of random content, then its end word.
    task automatic send_position();
        string letters;
        int n;
        int len;
        int pick;
        letters = "ACGTUNacgtunXz";
        n = $urandom_range(0, 14);
        for (int k = 0; k < n; k++)
        begin
            pick = $urandom_range(99);
            if (pick < 38)
                send_char(($urandom_range(1) != 0) ? "." : ",");
            else if (pick < 62)
                send_char(letters[$urandom_range(letters.len() - 1)]);
            else if (pick < 70)
                send_char(($urandom_range(1) != 0) ? "*" : "#");
            else if (pick < 80)
            begin
                send_char(($urandom_range(1) != 0) ? "+" : "-");
                len = $urandom_range(0, 12);
                if (len != 0 || $urandom_range(1) != 0)
                    send_text($sformatf("%0d", len));
                repeat (len) send_char(letters[$urandom_range(letters.len() - 1)]);
            end
            else if (pick < 86)
            begin
                send_char("^");
                send_char(8'($urandom_range(255)));
            end
            else if (pick < 92)
                send_char(($urandom_range(1) != 0) ? "$" : "<");
            else
                send_char(8'($urandom_range(255)));
        end
        pick = $urandom_range(99);
        send_eop((pick < 60) ? 16'(n + $urandom_range(0, 6)) :
                 (pick < 85) ? 16'($urandom_range(0, 300)) : 16'($urandom),
                 ($urandom_range(99) < 80) ? letters[$urandom_range(10)]
                                           : 8'($urandom_range(255)));
    endtask

    task automatic test_directed();
        send_text(".,ACGTUacgtuNn*#");
        send_eop(16'd20, "A");
        send_text("+2AC-3xyz^Ia$<>\t+AC-*");
        send_eop(16'd40, "g");
        send_text("+99999G..");
        send_eop(16'd25, "t");
        send_text("*****");
        send_eop(16'd2, "c");
        send_eop(16'hFFFF, "u");
        send_read(pnh_pkg::FUNC_BIN, 8'd0);
        send_read(pnh_pkg::FUNC_BIN, 8'd255);
        for (int k = 0; k < 4; k++)
            send_read(pnh_pkg::FUNC_TOT, 8'(k));
        send_read(pnh_pkg::FUNC_TOT, 8'd4);
        send_read(pnh_pkg::FUNC_TOT, 8'd255);
    endtask

    task automatic test_config_extremes();
        set_config(8'd0, 1'b0, pnh_pkg::DT_ALL);
        send_eop(16'd0, "A");
        send_text("AA");
        send_eop(16'd0, "C");
        set_config(8'd1, 1'b1, pnh_pkg::DT_MIS);
        send_text("..AG*+1c");
        send_eop(16'd1, "G");
        for (int dt = 0; dt < 8; dt++)
        begin
            set_config(8'd255, 1'b0, 3'(dt));
            send_text("AAC**+3ggg.,");
            send_eop(16'd255, "T");
            send_text("T");
            send_eop(16'd254, "A");
        end
        write_reg(pnh_pkg::REG_MIN_DEPTH, 8'hFF);
        write_reg(pnh_pkg::REG_PER_POSITION, 8'hFE);
        write_reg(pnh_pkg::REG_DIFF_TYPE, 8'hF8);
        send_position();
    endtask

    // Receiver holds off while positions keep coming, so the input has to stall.
    task automatic test_backpressure();
        set_config(8'd3, 1'b0, pnh_pkg::DT_ALL);
        send_idle = 0;
        recv_idle = 0;
        hold_left = 300;
        repeat (12) send_position();
        repeat (6) send_read(pnh_pkg::FUNC_BIN, 8'($urandom_range(0, 5)));
    endtask

    task automatic test_random();
        int start_count;
        int done;
        start_count = items_sent;
        done = 0;
        while (done < RANDOM_ITEMS)
        begin
            if (done < RANDOM_ITEMS / 3)
            begin
                send_idle = 37;
                recv_idle = 74;
            end
            else if (done < 2 * RANDOM_ITEMS / 3)
            begin
                send_idle = 74;
                recv_idle = 37;
            end
            else
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            case ($urandom_range(3))
                0: set_config(($urandom_range(1) != 0) ? 8'd1 : 8'd255,
                              1'($urandom_range(1)), 3'($urandom_range(7)));
                default: set_config(8'($urandom_range(1, 30)), ($urandom_range(3) == 0),
                                    3'($urandom_range(7)));
            endcase
            repeat (8)
            begin
                if ($urandom_range(9) < 7)
                    send_position();
                else if ($urandom_range(1) != 0)
                    send_read(pnh_pkg::FUNC_BIN,
                              ($urandom_range(3) == 0) ? 8'($urandom_range(255))
                                                       : 8'($urandom_range(31)));
                else
                    send_read(pnh_pkg::FUNC_TOT,
                              ($urandom_range(3) == 0) ? 8'($urandom_range(255))
                                                       : 8'($urandom_range(3)));
            end
            done = items_sent - start_count;
        end
        for (int b = 0; b < 32; b++)
            send_read(pnh_pkg::FUNC_BIN, 8'(b));
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.payload = '0;
        cfg.valid = 1'b0;
        cfg.payload = '0;
        out_ch.ready = 1'b0;
        send_idle = 0;
        recv_idle = 0;
        hold_left = 0;
        errors = 0;
        items_sent = 0;
        words_checked = 0;
        binned_positions = 0;
        stall_cycles = 0;
        min_depth_q = 8'd20;
        per_position_q = 1'b0;
        diff_type_q = pnh_pkg::DT_ALL;
        clear_position();
        for (int b = 0; b < pnh_pkg::MAX_BINS; b++)
            hist_bins[b] = '0;
        for (int k = 0; k < 4; k++)
            run_totals[k] = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_config_extremes();
        test_backpressure();
        test_random();
        drain();

        if (expected_words.size() != 0)
        begin
            $display("%0d result words never arrived", expected_words.size());
            errors++;
        end
        $display("Sent %0d item words and checked %0d result words, %0d positions binned,",
                 items_sent, words_checked, binned_positions);
        $display("under all diff types, both report modes and depth limits 0 to 255.");
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/pnh_pkg.sv
hdl/pnh_if.sv
hdl/pnh_div.sv
hdl/pileup_noise_histogram_core.sv
verif/testbench.sv
